### hw/rtl/assert_macros.svh
// assertion helpers for the return buffer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock outside reset
`define OMRB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// two conditions never true together
`define OMRB_ASSERT_EXCL(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) else $error(msg);

`endif

### hw/rtl/omrb_pkg.sv
`default_nettype none
package omrb_pkg;
    localparam int FIFO_DEPTH_DEF   = 16;
    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int WAVE_COUNT_DEF   = 64;

    localparam int TAG_W   = 16;
    localparam int WAVE_W  = 6;
    localparam int KIND_W  = 3;
    localparam int LIMIT_W = 7;
    localparam int COUNT_W = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;

    localparam logic [KIND_W-1:0] KIND_LOAD     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STORE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ATOMIC   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MEM_SYNC = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END_SYNC = 3'd4;

    typedef enum logic [1:0] {
        CREDIT_LOAD,
        CREDIT_STORE,
        CREDIT_NONE
    } credit_t;

    function automatic credit_t credit_class(input logic [KIND_W-1:0] kind);
        credit_t c;
        if (kind == KIND_LOAD || kind == KIND_ATOMIC)
            c = CREDIT_LOAD;
        else if (kind == KIND_STORE)
            c = CREDIT_STORE;
        else
            c = CREDIT_NONE;
        return c;
    endfunction

    typedef struct packed {
        logic              push_valid;
        logic [TAG_W-1:0]  push_tag;
        logic [WAVE_W-1:0] push_wave;
        logic [KIND_W-1:0] push_kind;
        logic              push_no_lanes;
        logic              resp_valid;
        logic [TAG_W-1:0]  resp_tag;
        logic              return_ready;
    } in_word_t;

    typedef struct packed {
        logic               push_accepted;
        logic               retire_valid;
        logic [TAG_W-1:0]   retire_tag;
        logic [WAVE_W-1:0]  retire_wave;
        logic [KIND_W-1:0]  retire_kind;
        logic               issue_valid;
        logic [TAG_W-1:0]   issue_tag;
        logic               issue_blocked;
        logic [COUNT_W-1:0] pending_count;
    } out_word_t;

    typedef struct packed {
        logic latch;
        logic scan_clear;
        logic resp_step;
        logic ret_step;
        logic issue;
    } dp_cmd_t;

    typedef struct packed {
        logic resp_valid;
        logic return_ready;
        logic buf_empty;
        logic scan_last;
        logic resp_hit;
        logic ret_hit;
        logic count_ok;
    } dp_status_t;
endpackage
`default_nettype wire

### hw/rtl/omrb_chan_if.sv
`default_nettype none
interface omrb_chan_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/omrb_datapath.sv
`default_nettype none
module omrb_datapath #(
    parameter int FIFO_DEPTH   = omrb_pkg::FIFO_DEPTH_DEF,
    parameter int BUFFER_DEPTH = omrb_pkg::BUFFER_DEPTH_DEF,
    parameter int WAVE_COUNT   = omrb_pkg::WAVE_COUNT_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire [omrb_pkg::LIMIT_W-1:0]          cfg_data,
    input  omrb_pkg::in_word_t                   in_word,
    input  omrb_pkg::dp_cmd_t                    cmd,
    output omrb_pkg::dp_status_t                 status,
    output omrb_pkg::out_word_t                  out_word
);
    import omrb_pkg::*;

    localparam int F_IDX_W = $clog2(FIFO_DEPTH);
    localparam int F_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int IDX_W   = $clog2(BUFFER_DEPTH);
    localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
    localparam int SLOT_W  = $clog2(WAVE_COUNT);
    localparam int WAVES   = 1 << WAVE_W;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [WAVE_W-1:0] wave;
        logic [KIND_W-1:0] kind;
        logic              no_lanes;
    } fifo_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [WAVE_W-1:0] wave;
        logic [KIND_W-1:0] kind;
    } buf_item_t;

    typedef logic [SLOT_W-1:0] slot_tab_t [WAVES];

    function automatic slot_tab_t build_slots();
        slot_tab_t t;
        for (int k = 0; k < WAVES; k++)
        begin
            t[k] = SLOT_W'(k % WAVE_COUNT);
        end
        return t;
    endfunction

    localparam slot_tab_t WAVE_SLOT = build_slots();

    in_word_t             lat_reg;
    out_word_t            res_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    fifo_item_t           fifo_reg [FIFO_DEPTH];
    logic [F_IDX_W-1:0]   head_reg;
    logic [F_CNT_W-1:0]   fcount_reg;
    buf_item_t            ent_reg [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] done_reg;
    logic [CNT_W-1:0]     used_reg;
    logic [LIMIT_W-1:0]   loads_reg;
    logic [LIMIT_W-1:0]   stores_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [WAVE_COUNT-1:0] seen_reg;

    buf_item_t            cur;
    logic [SLOT_W-1:0]    cur_slot;
    credit_t              cur_cls;
    fifo_item_t           head_item;
    credit_t              head_cls;
    logic                 credit_block;
    logic                 needs_entry;
    logic                 go;
    logic                 push_ok;
    logic [F_CNT_W-1:0]   fcount_after;
    logic [F_CNT_W:0]     tail_sum;
    logic [F_IDX_W-1:0]   tail;
    logic [F_IDX_W-1:0]   head_inc;
    logic [CNT_W-1:0]     used_next;
    logic [CNT_W+COUNT_W-1:0] used_wide;

    always_comb
    begin
        cur          = ent_reg[idx_reg];
        cur_slot     = WAVE_SLOT[cur.wave];
        cur_cls      = credit_class(cur.kind);
        head_item    = fifo_reg[head_reg];
        head_cls     = credit_class(head_item.kind);
        credit_block = (head_cls == CREDIT_LOAD && loads_reg >= limit_reg)
                    || (head_cls == CREDIT_STORE && stores_reg >= limit_reg);
        needs_entry  = head_item.kind != KIND_END_SYNC;
        go           = (fcount_reg != '0) && !credit_block
                    && !(needs_entry && used_reg == CNT_W'(BUFFER_DEPTH));
        fcount_after = go ? fcount_reg - F_CNT_W'(1) : fcount_reg;
        push_ok      = lat_reg.push_valid && (fcount_after < F_CNT_W'(FIFO_DEPTH));
        tail_sum     = (F_CNT_W+1)'(head_reg) + (F_CNT_W+1)'(fcount_reg);
        if (tail_sum >= (F_CNT_W+1)'(FIFO_DEPTH))
            tail_sum = tail_sum - (F_CNT_W+1)'(FIFO_DEPTH);
        tail         = tail_sum[F_IDX_W-1:0];
        head_inc     = (head_reg == F_IDX_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + F_IDX_W'(1);
        used_next    = (go && needs_entry) ? used_reg + CNT_W'(1) : used_reg;
        used_wide    = {{COUNT_W{1'b0}}, used_next};
    end

    assign status.resp_valid   = lat_reg.resp_valid;
    assign status.return_ready = lat_reg.return_ready;
    assign status.buf_empty    = used_reg == '0;
    assign status.scan_last    = (CNT_W'(idx_reg) + CNT_W'(1)) == used_reg;
    assign status.resp_hit     = !done_reg[idx_reg] && cur.tag == lat_reg.resp_tag;
    assign status.ret_hit      = done_reg[idx_reg] && !seen_reg[cur_slot];
    assign status.count_ok     = used_reg <= CNT_W'(BUFFER_DEPTH);
    assign out_word            = res_reg;

    // payload storage
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            lat_reg <= in_word;
        end
        if (cmd.ret_step && status.ret_hit)
        begin
            for (int j = 0; j < BUFFER_DEPTH - 1; j++)
            begin
                if (IDX_W'(j) >= idx_reg)
                    ent_reg[j] <= ent_reg[j+1];
            end
        end
        if (cmd.issue && go && needs_entry)
        begin
            ent_reg[used_reg[IDX_W-1:0]] <= '{tag: head_item.tag, wave: head_item.wave,
                                              kind: head_item.kind};
        end
        if (cmd.issue && push_ok)
        begin
            fifo_reg[tail] <= '{tag: lat_reg.push_tag, wave: lat_reg.push_wave,
                                kind: lat_reg.push_kind, no_lanes: lat_reg.push_no_lanes};
        end
        if (cmd.latch)
        begin
            res_reg <= '0;
        end
        else
        begin
            if (cmd.ret_step && status.ret_hit)
            begin
                res_reg.retire_valid <= 1'b1;
                res_reg.retire_tag   <= cur.tag;
                res_reg.retire_wave  <= cur.wave;
                res_reg.retire_kind  <= cur.kind;
            end
            if (cmd.issue)
            begin
                res_reg.push_accepted <= push_ok;
                res_reg.issue_valid   <= go;
                res_reg.issue_tag     <= go ? head_item.tag : '0;
                res_reg.issue_blocked <= (fcount_reg != '0) && credit_block;
                res_reg.pending_count <= used_wide[COUNT_W-1:0];
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            head_reg   <= '0;
            fcount_reg <= '0;
            done_reg   <= '0;
            used_reg   <= '0;
            loads_reg  <= '0;
            stores_reg <= '0;
            idx_reg    <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_data;

            if (cmd.latch || cmd.scan_clear)
            begin
                idx_reg  <= '0;
                seen_reg <= '0;
            end
            else if (cmd.resp_step || cmd.ret_step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (cmd.resp_step && status.resp_hit)
                done_reg[idx_reg] <= 1'b1;

            if (cmd.ret_step)
            begin
                if (status.ret_hit)
                begin
                    for (int j = 0; j < BUFFER_DEPTH - 1; j++)
                    begin
                        if (IDX_W'(j) >= idx_reg)
                            done_reg[j] <= done_reg[j+1];
                    end
                    used_reg <= used_reg - CNT_W'(1);
                    if (cur_cls == CREDIT_LOAD && loads_reg != '0)
                        loads_reg <= loads_reg - LIMIT_W'(1);
                    if (cur_cls == CREDIT_STORE && stores_reg != '0)
                        stores_reg <= stores_reg - LIMIT_W'(1);
                end
                else if (!done_reg[idx_reg] && !cmd.scan_clear)
                begin
                    seen_reg[cur_slot] <= 1'b1;
                end
            end

            if (cmd.issue)
            begin
                if (go)
                begin
                    head_reg <= head_inc;
                    if (head_cls == CREDIT_LOAD)
                        loads_reg <= loads_reg + LIMIT_W'(1);
                    if (head_cls == CREDIT_STORE)
                        stores_reg <= stores_reg + LIMIT_W'(1);
                    if (needs_entry)
                        done_reg[used_reg[IDX_W-1:0]] <= (head_cls != CREDIT_NONE)
                                                         && head_item.no_lanes;
                end
                used_reg   <= used_next;
                fcount_reg <= push_ok ? fcount_after + F_CNT_W'(1) : fcount_after;
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/omrb_ctrl.sv
`default_nettype none
module omrb_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire                   out_ready,
    input  omrb_pkg::dp_status_t  status,
    output omrb_pkg::dp_cmd_t     cmd
);
    import omrb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_RETIRE,
        S_ISSUE,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (status.resp_valid && !status.buf_empty)
                begin
                    cmd.resp_step = 1'b1;
                    if (status.resp_hit || status.scan_last)
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_RETIRE;
                    end
                end
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_RETIRE;
                end
            end
            S_RETIRE:
            begin
                if (status.return_ready && !status.buf_empty)
                begin
                    cmd.ret_step = 1'b1;
                    if (status.ret_hit || status.scan_last)
                        state_next = S_ISSUE;
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= state_next == S_IDLE;
            out_valid_reg <= state_next == S_OUT;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/ordered_memory_return_buffer.sv
// ordered memory return buffer
// in_ch carries one word per compute unit cycle: an optional push into the
// issue fifo, an optional response tag and the return-ready flag. out_ch
// returns one word per input word: push accepted, the retired entry, the
// issued fifo head, the blocked flag and the buffer occupancy.
// cfg_we/cfg_data write the per-class in-flight limit (reset 16).
// one word is processed at a time. after acceptance a word goes through the
// response tag match over the held entries, the retire search over the held
// entries and then issue and push before out_ch goes valid. both searches
// walk the response buffer one entry per cycle and stop at the first hit.
// in_ch ready is high only while no word is in flight. a result stays on
// out_ch until taken; a stalled receiver holds off the next input word.
// the next word can be accepted in the cycle after the result is taken, so
// a word passes through the idle, response, retire, issue and output states.
// reset empties the fifo and the response buffer and clears both credit
// counters; in_ch is ready out of reset.
`default_nettype none
`include "assert_macros.svh"
module ordered_memory_return_buffer #(
    parameter int FIFO_DEPTH   = omrb_pkg::FIFO_DEPTH_DEF,
    parameter int BUFFER_DEPTH = omrb_pkg::BUFFER_DEPTH_DEF,
    parameter int WAVE_COUNT   = omrb_pkg::WAVE_COUNT_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    omrb_chan_if.sink                    in_ch,
    omrb_chan_if.source                  out_ch,
    input  wire                          cfg_we,
    input  wire [omrb_pkg::LIMIT_W-1:0]  cfg_data
);
    import omrb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    omrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    omrb_datapath #(
        .FIFO_DEPTH   (FIFO_DEPTH),
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .WAVE_COUNT   (WAVE_COUNT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_word  (in_ch.data),
        .cmd      (cmd),
        .status   (status),
        .out_word (out_ch.data)
    );

    `OMRB_ASSERT_EXCL(a_busy_excl, in_ch.ready, out_ch.valid, "ready while result pending")
    `OMRB_ASSERT(a_count_range, status.count_ok, "response buffer count overflow")
    `OMRB_ASSERT(a_issue_block, out_ch.valid |-> !(out_ch.data.issue_valid && out_ch.data.issue_blocked), "issued while blocked")
endmodule
`default_nettype wire
